// ----- rtl/coh_pkg.sv -----
// ----------------------------------------------------------------------------
// coh_pkg
// Shared types, constants and a step function for the ring/disk overlap angle.
// ----------------------------------------------------------------------------
package coh_pkg;

    localparam int COORD_W     = 16;
    localparam int ANGLE_W     = 16;
    localparam int SQRT_STEPS  = 32;
    localparam int CORDIC_STEPS = 31;
    localparam int XY_W        = 36;
    localparam int ACC_W       = 33;

    localparam logic [33:0] PI_Q30 = 34'd3373259426;

    // configuration register indexes
    localparam logic [1:0] REG_DISK_RADIUS = 2'd0;
    localparam logic [1:0] REG_CENTER_SEP  = 2'd1;

    typedef enum logic [1:0] {
        KIND_ZERO,
        KIND_PI,
        KIND_PART
    } kind_t;

    typedef struct packed {
        logic [63:0] vx;
        logic [63:0] rx;
        logic [63:0] vy;
        logic [63:0] ry;
        kind_t       kind;
        logic        last;
    } sqrt_t;

    typedef struct packed {
        logic signed [XY_W-1:0]  x;
        logic signed [XY_W-1:0]  y;
        logic signed [ACC_W-1:0] acc;
        kind_t                   kind;
        logic                    last;
    } cordic_t;

    // round(atan(2^-i) * 2^30)
    function automatic logic signed [ACC_W-1:0] atan_q30(input logic [4:0] i);
        logic signed [ACC_W-1:0] t;
        case (i)
            5'd0:    t = 33'sd843314857;
            5'd1:    t = 33'sd497837829;
            5'd2:    t = 33'sd263043837;
            5'd3:    t = 33'sd133525159;
            5'd4:    t = 33'sd67021687;
            5'd5:    t = 33'sd33543516;
            5'd6:    t = 33'sd16775851;
            5'd7:    t = 33'sd8388437;
            5'd8:    t = 33'sd4194283;
            5'd9:    t = 33'sd2097149;
            5'd10:   t = 33'sd1048576;
            default: t = $signed(33'd1 << (5'd30 - i));
        endcase
        return t;
    endfunction

endpackage

// ----- rtl/circle_overlap_half_angle.sv -----
// ----------------------------------------------------------------------------
// circle_overlap_half_angle
// Half central angle of a ring's arc that lies inside an offset disk.
// ----------------------------------------------------------------------------
// One item per cycle, unless the output stalls, through four front stages (classify, two
// 18x18 products, leading-zero count, normalizing shift), a row of 32 square
// root cells, a row of 31 CORDIC cells, and one rounding stage. Every stage
// holds its item until the next one frees up, so a waiting result stalls
// only the stages behind it. The angle is radians with 14 fraction bits,
// 51472 for pi. Write disk_radius and center_separation only while no item
// is in flight.
module circle_overlap_half_angle
    import coh_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [COORD_W-1:0] cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [COORD_W-1:0] ring_radius,
    input  logic               last_in,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [ANGLE_W-1:0] half_angle,
    output logic               last_out
);

    localparam int NST   = 4 + SQRT_STEPS + CORDIC_STEPS + 1;
    localparam int SQ0   = 4;
    localparam int CO0   = SQ0 + SQRT_STEPS;
    localparam int LASTS = NST - 1;

    logic [COORD_W-1:0] disk_reg;
    logic [COORD_W-1:0] sep_reg;
    logic [NST-1:0]     v_reg;
    logic [NST-1:0]     en;

    // stage enables ripple back from the output
    always_comb
    begin
        en[LASTS] = !v_reg[LASTS] || out_ready;
        for (int i = LASTS - 1; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign in_ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disk_reg <= '0;
            sep_reg  <= '0;
            v_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_DISK_RADIUS: disk_reg <= cfg_data;
                    REG_CENTER_SEP:  sep_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i < NST; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // ---------------- stage 0: classify, side lengths ----------------
    logic [17:0] r18, p18, z18;
    logic [17:0] a_next, b_next, c_next, d_next;
    kind_t       kind0_next;
    logic [17:0] a_reg, b_reg, c_reg, d_reg;
    kind_t       kind0_reg;
    logic        last0_reg;

    always_comb
    begin
        r18    = {2'b00, ring_radius};
        p18    = {2'b00, disk_reg};
        z18    = {2'b00, sep_reg};
        a_next = p18 + z18 - r18;
        b_next = p18 + r18 - z18;
        c_next = r18 + z18 - p18;
        d_next = r18 + z18 + p18;
        if (r18 + z18 <= p18)
        begin
            kind0_next = KIND_PI;
        end
        else if ((r18 < p18 + z18) && (r18 + p18 > z18))
        begin
            kind0_next = KIND_PART;
        end
        else
        begin
            kind0_next = KIND_ZERO;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            a_reg     <= a_next;
            b_reg     <= b_next;
            c_reg     <= c_next;
            d_reg     <= d_next;
            kind0_reg <= kind0_next;
            last0_reg <= last_in;
        end
    end

    // ---------------- stage 1: products ----------------
    logic [35:0] ab1_reg, cd1_reg;
    kind_t       kind1_reg;
    logic        last1_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            ab1_reg   <= a_reg * b_reg;
            cd1_reg   <= c_reg * d_reg;
            kind1_reg <= kind0_reg;
            last1_reg <= last0_reg;
        end
    end

    // ---------------- stage 2: normalize count ----------------
    logic [35:0] m1;
    logic [5:0]  q1;
    logic [6:0]  k7;
    logic [4:0]  k_next;
    logic [35:0] ab2_reg, cd2_reg;
    logic [4:0]  k_reg;
    kind_t       kind2_reg;
    logic        last2_reg;

    always_comb
    begin
        m1 = (ab1_reg > cd1_reg) ? ab1_reg : cd1_reg;
        q1 = '0;
        for (int j = 0; j < 36; j++)
        begin
            if (m1[j])
            begin
                q1 = 6'(j);
            end
        end
        // smallest k with msb + 2k >= 60
        k7     = (7'd61 - {1'b0, q1}) >> 1;
        k_next = (m1 == '0) ? 5'd0 : k7[4:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            ab2_reg   <= ab1_reg;
            cd2_reg   <= cd1_reg;
            k_reg     <= k_next;
            kind2_reg <= kind1_reg;
            last2_reg <= last1_reg;
        end
    end

    // ---------------- stage 3: shift ----------------
    sqrt_t sq [0:SQRT_STEPS];
    sqrt_t sq_first_reg;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            sq_first_reg.vx   <= {28'd0, cd2_reg} << {k_reg, 1'b0};
            sq_first_reg.vy   <= {28'd0, ab2_reg} << {k_reg, 1'b0};
            sq_first_reg.rx   <= '0;
            sq_first_reg.ry   <= '0;
            sq_first_reg.kind <= kind2_reg;
            sq_first_reg.last <= last2_reg;
        end
    end

    assign sq[0] = sq_first_reg;

    genvar g;
    generate
        for (g = 0; g < SQRT_STEPS; g++)
        begin : g_sqrt
            coh_sqrt_cell u_cell (
                .clk   (clk),
                .en    (en[SQ0+g]),
                .idx   (5'(g)),
                .d_in  (sq[g]),
                .d_out (sq[g+1])
            );
        end
    endgenerate

    // roots to rotator, with degenerate roots resolved
    cordic_t co [0:CORDIC_STEPS];
    sqrt_t   sqe;

    always_comb
    begin
        sqe          = sq[SQRT_STEPS];
        co[0].x      = $signed({4'd0, sqe.rx[31:0]});
        co[0].y      = $signed({4'd0, sqe.ry[31:0]});
        co[0].acc    = '0;
        co[0].last   = sqe.last;
        co[0].kind   = sqe.kind;
        if (sqe.kind == KIND_PART)
        begin
            if (sqe.ry[31:0] == '0)
            begin
                co[0].kind = KIND_ZERO;
            end
            else if (sqe.rx[31:0] == '0)
            begin
                co[0].kind = KIND_PI;
            end
        end
    end

    generate
        for (g = 0; g < CORDIC_STEPS; g++)
        begin : g_cordic
            coh_cordic_cell u_cell (
                .clk   (clk),
                .en    (en[CO0+g]),
                .idx   (5'(g)),
                .d_in  (co[g]),
                .d_out (co[g+1])
            );
        end
    endgenerate

    // ---------------- output stage: double, clamp, round ----------------
    cordic_t            ce;
    logic signed [33:0] acc2;
    logic [33:0]        ang;
    logic [33:0]        rnd;
    logic [ANGLE_W-1:0] angle_next;
    logic [ANGLE_W-1:0] angle_reg;
    logic               last_reg;

    always_comb
    begin
        ce   = co[CORDIC_STEPS];
        acc2 = {ce.acc, 1'b0};
        case (ce.kind)
            KIND_PI:   ang = PI_Q30;
            KIND_PART:
            begin
                if (acc2[33])
                begin
                    ang = '0;
                end
                else if ($unsigned(acc2) > PI_Q30)
                begin
                    ang = PI_Q30;
                end
                else
                begin
                    ang = $unsigned(acc2);
                end
            end
            default:   ang = '0;
        endcase
        rnd        = ang + 34'd32768;
        angle_next = rnd[31:16];
    end

    always_ff @(posedge clk)
    begin
        if (en[LASTS])
        begin
            angle_reg <= angle_next;
            last_reg  <= ce.last;
        end
    end

    assign out_valid  = v_reg[LASTS];
    assign half_angle = angle_reg;
    assign last_out   = last_reg;

    // ---------------- assertions ----------------
    a_drain_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |-> in_ready)
        else $error("input blocked while output drains");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> half_angle <= 16'd51472)
        else $error("angle above pi");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg == '0 |-> in_ready)
        else $error("empty pipeline not ready");

    a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[LASTS] && !out_ready |=> v_reg[LASTS])
        else $error("result dropped");

endmodule

// ----- rtl/coh_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// coh_sqrt_cell
// One digit step of the bit-by-bit integer square root, for both operands.
// ----------------------------------------------------------------------------
module coh_sqrt_cell
    import coh_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [4:0]  idx,
    input  sqrt_t       d_in,
    output sqrt_t       d_out
);

    sqrt_t       d_reg;
    sqrt_t       d_next;
    logic [63:0] bitv;
    logic [63:0] tx;
    logic [63:0] ty;

    always_comb
    begin
        bitv   = 64'h4000_0000_0000_0000 >> {idx, 1'b0};
        tx     = d_in.rx + bitv;
        ty     = d_in.ry + bitv;
        d_next = d_in;
        if (d_in.vx >= tx)
        begin
            d_next.vx = d_in.vx - tx;
            d_next.rx = (d_in.rx >> 1) + bitv;
        end
        else
        begin
            d_next.rx = d_in.rx >> 1;
        end
        if (d_in.vy >= ty)
        begin
            d_next.vy = d_in.vy - ty;
            d_next.ry = (d_in.ry >> 1) + bitv;
        end
        else
        begin
            d_next.ry = d_in.ry >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule

// ----- rtl/coh_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// coh_cordic_cell
// One vectoring rotation: drives y toward zero and accumulates the angle.
// ----------------------------------------------------------------------------
module coh_cordic_cell
    import coh_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [4:0]  idx,
    input  cordic_t     d_in,
    output cordic_t     d_out
);

    cordic_t                 d_reg;
    cordic_t                 d_next;
    logic signed [XY_W-1:0]  sx;
    logic signed [XY_W-1:0]  sy;
    logic signed [ACC_W-1:0] t;

    always_comb
    begin
        sx     = d_in.x >>> idx;
        sy     = d_in.y >>> idx;
        t      = atan_q30(idx);
        d_next = d_in;
        if (!d_in.y[XY_W-1])
        begin
            d_next.x   = d_in.x + sy;
            d_next.y   = d_in.y - sx;
            d_next.acc = d_in.acc + t;
        end
        else
        begin
            d_next.x   = d_in.x - sy;
            d_next.y   = d_in.y + sx;
            d_next.acc = d_in.acc - t;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule
